// ===== hw/rtl/nja_pkg.sv =====
// ----------------------------------------------------------------------------
// nja_pkg
// Shared types and constants for the nearest joint assignment block.
// ----------------------------------------------------------------------------
package nja_pkg;

   localparam int MAX_JOINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int ADDR_W     = $clog2(MAX_JOINTS);
   localparam int CNT_W      = $clog2(MAX_JOINTS + 1);
   localparam int CSR_W      = 7;
   localparam int ID_W       = 8;
   localparam int MAG_W      = COORD_BITS;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int DIST_W     = SQ_W + 2;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                         req_type;
      logic [ADDR_W-1:0]            joint_slot;
      logic [ID_W-1:0]              joint_id;
      logic                         joint_is_root;
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
   } req_word_type;

   typedef struct packed {
      logic [ID_W-1:0] nearest_joint_id;
      logic            found;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
   } point_type;

   typedef struct packed {
      point_type       pos;
      logic [ID_W-1:0] id;
      logic            root;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } tbl_ctl_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              root;
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] sq_dist;
   } dist_out_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/nearest_joint_assign_core.sv =====
// ----------------------------------------------------------------------------
// nearest_joint_assign_core
// Joint table with brute-force nearest non-root joint search per vertex.
//
//   port group   dir   handshake          word
//   req_*        in    valid / stall      load joint or query vertex
//   rsp_*        out   valid / stall      nearest id and found flag
//   csr_*        in    write enable       joint_count
//
// A load writes the table when it is taken. A query with
// n = min(joint_count,64) above zero makes one table read per cycle;
// then the memory read and the three-stage distance pipe drain before
// the result is registered. A zero count skips the scan.
// Synchronous active-high reset clears control; table contents stay
// undefined until loaded. Input stalls during a search and while a
// finished result cannot be registered behind an untaken one.
// ----------------------------------------------------------------------------
module nearest_joint_assign_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nja_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nja_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [nja_pkg::CSR_W-1:0] csr_wr_data
);
   import nja_pkg::*;

   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  count_ff;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [ADDR_W-1:0] addr_ff;
   point_type         vtx_ff;
   tag_type           rd_tag_ff;
   logic              have_ff;
   logic [DIST_W-1:0] best_ff;
   logic [ID_W-1:0]   best_id_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;

   tbl_ctl_type  tbl_ctl;
   entry_type    rd_entry;
   dist_out_type dout;
   tag_type      issue;
   logic         req_acc, is_query, last_issue, rsp_free, rsp_load, better;

   assign req_acc  = req_valid && !req_stall;
   assign is_query = req_word.req_type == REQ_QUERY;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign last_issue = (CNT_W'(addr_ff) + CNT_W'(1)) == n_ff;
   assign n_in = (CNT_W'(count_ff) > CNT_W'(MAX_JOINTS)) ?
                 CNT_W'(MAX_JOINTS) : CNT_W'(count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_query) begin
               state_in = (n_in == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dout.valid && dout.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      issue.valid = 1'b0;
      issue.last  = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SCAN: begin
            issue.valid = 1'b1;
            issue.last  = last_issue;
         end
         ST_DRAIN: ;
         ST_DONE:  rsp_load = rsp_free;
         default:  req_stall = 1'b1;
      endcase
   end

   // loads are taken only while idle, so no scan read overlaps a write
   assign tbl_ctl.wr_en         = req_acc && !is_query;
   assign tbl_ctl.wr_addr       = req_word.joint_slot;
   assign tbl_ctl.wr_data.pos.x_coord = req_word.x_coord;
   assign tbl_ctl.wr_data.pos.y_coord = req_word.y_coord;
   assign tbl_ctl.wr_data.pos.z_coord = req_word.z_coord;
   assign tbl_ctl.wr_data.id    = req_word.joint_id;
   assign tbl_ctl.wr_data.root  = req_word.joint_is_root;
   assign tbl_ctl.rd_addr       = addr_ff;

   nja_table u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .rd_data (rd_entry)
   );

   nja_dist u_dist (
      .clock (clock),
      .reset (reset),
      .tag   (rd_tag_ff),
      .entry (rd_entry),
      .vtx   (vtx_ff),
      .dout  (dout)
   );

   assign better = dout.valid && !dout.root && (!have_ff || (dout.sq_dist < best_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_tag_ff    <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         rd_tag_ff <= issue;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (req_acc && is_query) begin
            addr_ff <= '0;
            have_ff <= 1'b0;
         end else begin
            if (issue.valid) begin
               addr_ff <= addr_ff + ADDR_W'(1);
            end
            if (better) begin
               have_ff <= 1'b1;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && is_query) begin
         n_ff           <= n_in;
         vtx_ff.x_coord <= req_word.x_coord;
         vtx_ff.y_coord <= req_word.y_coord;
         vtx_ff.z_coord <= req_word.z_coord;
      end
      if (better) begin
         best_ff    <= dout.sq_dist;
         best_id_ff <= dout.id;
      end
      if (rsp_load) begin
         rsp_word_ff.found            <= have_ff;
         rsp_word_ff.nearest_joint_id <= have_ff ? best_id_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input taken during search");

   a_none_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.found || rsp_word.nearest_joint_id == '0))
      else $error("nonzero id without a match");

   a_pipe_in_search: assert property (@(posedge clock) disable iff (reset)
      dout.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance word outside a search");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (CNT_W'(addr_ff) < n_ff))
      else $error("read address beyond joint count");

endmodule

// ===== hw/rtl/nja_table.sv =====
// ----------------------------------------------------------------------------
// nja_table
// Joint table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nja_table (
   input  logic                clock,
   input  nja_pkg::tbl_ctl_type ctl,
   output nja_pkg::entry_type   rd_data
);
   import nja_pkg::*;

   entry_type mem [MAX_JOINTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/nja_dist.sv =====
// ----------------------------------------------------------------------------
// nja_dist
// Three-stage squared distance pipe: abs differences, squares, sum.
// ----------------------------------------------------------------------------
module nja_dist (
   input  logic                  clock,
   input  logic                  reset,
   input  nja_pkg::tag_type      tag,
   input  nja_pkg::entry_type    entry,
   input  nja_pkg::point_type    vtx,
   output nja_pkg::dist_out_type dout
);
   import nja_pkg::*;

   function automatic logic [MAG_W-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS:0] d;
      logic signed [COORD_BITS:0] m;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      m = d[COORD_BITS] ? -d : d;
      return m[MAG_W-1:0];
   endfunction

   tag_type           tag1_ff, tag2_ff, tag3_ff;
   logic              root1_ff, root2_ff, root3_ff;
   logic [ID_W-1:0]   id1_ff, id2_ff, id3_ff;
   logic [MAG_W-1:0]  mx_ff, my_ff, mz_ff;
   logic [SQ_W-1:0]   sx_ff, sy_ff, sz_ff;
   logic [DIST_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      root1_ff <= entry.root;
      id1_ff   <= entry.id;
      mx_ff    <= abs_diff(entry.pos.x_coord, vtx.x_coord);
      my_ff    <= abs_diff(entry.pos.y_coord, vtx.y_coord);
      mz_ff    <= abs_diff(entry.pos.z_coord, vtx.z_coord);

      root2_ff <= root1_ff;
      id2_ff   <= id1_ff;
      sx_ff    <= mx_ff * mx_ff;
      sy_ff    <= my_ff * my_ff;
      sz_ff    <= mz_ff * mz_ff;

      root3_ff <= root2_ff;
      id3_ff   <= id2_ff;
      sum_ff   <= DIST_W'(sx_ff) + DIST_W'(sy_ff) + DIST_W'(sz_ff);
   end

   assign dout.valid   = tag3_ff.valid;
   assign dout.last    = tag3_ff.last;
   assign dout.root    = root3_ff;
   assign dout.id      = id3_ff;
   assign dout.sq_dist = sum_ff;

endmodule
